### hdl/bdq_pkg.sv
// Shared definitions for the byte deque with key removal.
// Operation codes, field widths and the controller/datapath interface types.
// No dependencies.
`default_nettype none

package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KIND_W  = 2;
   localparam int VALUE_W = 8;
   localparam int COUNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_PUSH_TOP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BOTTOM = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR       = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // an input item is taken this cycle
      logic scan;      // one step of the removal compaction
      logic finish;    // close the removal and commit the new fill
      logic load_rsp;  // load the result registers
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_scan;  // the offered item is a removal on a nonempty list
      logic scan_done;   // every entry has been read and processed
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/bdq_ctrl.sv
// Controller for the byte deque: sequences accept, compaction and result hand-off.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new item when empty or when drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && out_free;
            if (cmd.accept) begin
               if (status.needs_scan) begin
                  state_in = ST_SCAN;
               end else begin
                  cmd.load_rsp = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hdl/bdq_dp.sv
// Datapath for the byte deque: circular entry memory, head and fill pointers,
// removal compaction and result registers. Depends on bdq_pkg.
`default_nettype none

module bdq_dp
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [VALUE_W-1:0]  req_value,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic [VALUE_W-1:0]  rsp_top_value,
   output logic                rsp_refused,
   output logic [COUNT_W-1:0]  rsp_removed_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ((AW > CW) ? AW : CW) + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   // Position of an entry counted from the head, with one wrap at DEPTH.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offset);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offset);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [VALUE_W-1:0] top_ff, top_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic               pend_ff, pend_in;

   logic [CW-1:0]      res_count_ff, res_count_in;
   logic [VALUE_W-1:0] res_top_ff, res_top_in;
   logic               res_refused_ff, res_refused_in;
   logic [CW-1:0]      res_removed_ff, res_removed_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      head_dec;
   logic               full;
   logic               empty;

   assign full     = (fill_ff == DEPTH_C);
   assign empty    = (fill_ff == '0);
   assign head_dec = (head_ff == '0) ? LAST_A : head_ff - AW'(1);
   assign rd_addr  = wrap_add(head_ff, rd_idx_ff);

   assign status.needs_scan = (req_kind == KIND_REMOVE) && !empty;
   assign status.scan_done  = (rd_idx_ff == fill_ff) && !pend_ff;

   always_comb begin
      head_in        = head_ff;
      fill_in        = fill_ff;
      top_in         = top_ff;
      key_in         = key_ff;
      rd_idx_in      = rd_idx_ff;
      kept_in        = kept_ff;
      pend_in        = pend_ff;
      res_count_in   = fill_ff;
      res_top_in     = top_ff;
      res_refused_in = 1'b0;
      res_removed_in = '0;
      wr_en          = 1'b0;
      wr_addr        = head_ff;
      wr_data        = req_value;

      if (cmd.accept) begin
         unique case (req_kind)
            KIND_PUSH_TOP: begin
               if (full) begin
                  res_refused_in = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = head_dec;
                  head_in      = head_dec;
                  fill_in      = fill_ff + CW'(1);
                  top_in       = req_value;
                  res_count_in = fill_ff + CW'(1);
                  res_top_in   = req_value;
               end
            end
            KIND_PUSH_BOTTOM: begin
               if (full) begin
                  res_refused_in = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = wrap_add(head_ff, fill_ff);
                  fill_in      = fill_ff + CW'(1);
                  res_count_in = fill_ff + CW'(1);
                  if (empty) begin
                     top_in     = req_value;
                     res_top_in = req_value;
                  end
               end
            end
            KIND_REMOVE: begin
               if (empty) begin
                  res_count_in = '0;
                  res_top_in   = '0;
               end else begin
                  key_in    = req_value;
                  rd_idx_in = '0;
                  kept_in   = '0;
                  pend_in   = 1'b0;
               end
            end
            KIND_CLEAR: begin
               fill_in        = '0;
               res_count_in   = '0;
               res_top_in     = '0;
               res_removed_in = fill_ff;
            end
            default: begin
            end
         endcase
      end

      // Compaction: read one entry per cycle, write survivors back in order.
      if (cmd.scan) begin
         if (rd_idx_ff != fill_ff) begin
            rd_idx_in = rd_idx_ff + CW'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && (rd_data_ff != key_ff)) begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_ff, kept_ff);
            wr_data = rd_data_ff;
            kept_in = kept_ff + CW'(1);
            if (kept_ff == '0) begin
               top_in = rd_data_ff;
            end
         end
      end

      if (cmd.finish) begin
         fill_in        = kept_ff;
         res_count_in   = kept_ff;
         res_top_in     = (kept_ff != '0) ? top_ff : '0;
         res_removed_in = fill_ff - kept_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         rd_idx_ff <= '0;
         kept_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         rd_idx_ff <= rd_idx_in;
         kept_ff   <= kept_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      key_ff <= key_in;
      if (cmd.load_rsp) begin
         res_count_ff   <= res_count_in;
         res_top_ff     <= res_top_in;
         res_refused_ff <= res_refused_in;
         res_removed_ff <= res_removed_in;
      end
   end

   // Counts leave on five bits; deeper lists wrap there.
   logic [CW+COUNT_W-1:0] count_ext;
   logic [CW+COUNT_W-1:0] removed_ext;

   assign count_ext         = {{COUNT_W{1'b0}}, res_count_ff};
   assign removed_ext       = {{COUNT_W{1'b0}}, res_removed_ff};
   assign rsp_count         = count_ext[COUNT_W-1:0];
   assign rsp_removed_count = removed_ext[COUNT_W-1:0];
   assign rsp_top_value     = res_top_ff;
   assign rsp_refused       = res_refused_ff;

endmodule

`default_nettype wire

### hdl/byte_deque_with_key_removal.sv
// Byte deque with key removal. Holds up to DEPTH bytes in order; each item pushes a
// byte at the top or the bottom, removes every entry equal to a key, or clears the
// list, and returns one result with the new count, the top byte (zero when empty),
// a refused flag for a push into a full list and the number of entries deleted.
// Pushes, clears and removals on an empty list load the result on acceptance, and the
// next item may follow at once. In a removal on a nonempty list, the
// compaction reads one entry per cycle from the single-read-port entry memory and
// writes survivors back behind it. The result sits in an output register; a new
// item is taken while a result waits only in the cycle that the result is taken.
// Depends on bdq_pkg, bdq_ctrl and bdq_dp.
`default_nettype none

module byte_deque_with_key_removal
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [VALUE_W-1:0] rsp_top_value,
   output logic               rsp_refused,
   output logic [COUNT_W-1:0] rsp_removed_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_value         (req_value),
      .rsp_count         (rsp_count),
      .rsp_top_value     (rsp_top_value),
      .rsp_refused       (rsp_refused),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

`default_nettype wire

### hdl/bdq_checker.sv
// Port-level checks for the byte deque, attached to the top level by bind.
// Depends on bdq_pkg and byte_deque_with_key_removal.
`default_nettype none

module bdq_checker
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [KIND_W-1:0]  req_kind,
   input logic [VALUE_W-1:0] req_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COUNT_W-1:0] rsp_count,
   input logic [VALUE_W-1:0] rsp_top_value,
   input logic               rsp_refused,
   input logic [COUNT_W-1:0] rsp_removed_count
);

   localparam logic [COUNT_W-1:0] DEPTH_OUT = COUNT_W'(DEPTH);

   // A refused push leaves a full list and deletes nothing.
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> (rsp_count == DEPTH_OUT) && (rsp_removed_count == '0))
      else $error("refused item without a full list");

   // An empty list reports a zero top byte.
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_count == '0) |-> (rsp_top_value == '0))
      else $error("empty list with nonzero top byte");

   // The count never exceeds the capacity where it fits in the field.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 31) || (rsp_count <= DEPTH_OUT))
      else $error("count above capacity");

   // A push of a byte into a nonfull top position shows it as the top.
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_PUSH_TOP) && !rsp_valid |=>
         rsp_valid && (rsp_refused || (rsp_top_value == $past(req_value))))
      else $error("pushed byte not at the top");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count)
         && $stable(rsp_top_value) && $stable(rsp_refused) && $stable(rsp_removed_count))
      else $error("result changed while stalled");

endmodule

bind byte_deque_with_key_removal bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_kind          (req_kind),
   .req_value         (req_value),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_count         (rsp_count),
   .rsp_top_value     (rsp_top_value),
   .rsp_refused       (rsp_refused),
   .rsp_removed_count (rsp_removed_count)
);

`default_nettype wire
